@@ hdl/qvu_pkg.sv @@
// qvu_pkg: shared types and constants for the tabular q value update unit
// no dependencies; imported by qvu_qtable, qvu_arith and the top level
`default_nettype none

package qvu_pkg;

    // default table geometry
    localparam int DEF_NUM_STATES  = 256;
    localparam int DEF_NUM_ACTIONS = 8;

    // fixed field widths
    localparam int STATE_IN_W  = 8;
    localparam int ACTION_IN_W = 3;
    localparam int Q_W         = 32;
    localparam int BEST_W      = 31;
    localparam int FRAC_W      = 16;
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_FACTOR = 2'd1;

    // configuration reset values
    localparam logic [FRAC_W-1:0] ALPHA_RESET = 16'd6554;
    localparam logic [FRAC_W-1:0] GAMMA_RESET = 16'd58982;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_QREAD,
        ST_MUL1,
        ST_SUB,
        ST_MUL2,
        ST_SAT,
        ST_WRITE,
        ST_OUT
    } t_state;

    // stage enables from the sequencer to the arithmetic unit
    typedef struct packed {
        logic accept;
        logic cmp;
        logic mul1;
        logic sub;
        logic mul2;
        logic sat;
    } t_arith_ctl;

endpackage

`default_nettype wire

@@ hdl/qvu_qtable.sv @@
// qvu_qtable: simple dual port q value memory, one write and one registered read per cycle
// depends on qvu_pkg
`default_nettype none

module qvu_qtable
    import qvu_pkg::*;
#(
    parameter int ADDR_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [Q_W-1:0]    i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [Q_W-1:0]    o_rdata
);

    logic [Q_W-1:0] mem [1 << ADDR_W];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/qvu_arith.sv @@
// qvu_arith: row maximum tracking and the q update arithmetic with saturation
// depends on qvu_pkg
`default_nettype none

module qvu_arith
    import qvu_pkg::*;
#(
    parameter int AW = 3
) (
    input  wire logic                    i_clk,
    input  wire t_arith_ctl              i_ctl,
    input  wire logic [FRAC_W-1:0]       i_alpha,
    input  wire logic [FRAC_W-1:0]       i_gamma,
    input  wire logic signed [Q_W-1:0]   i_reward,
    input  wire logic [Q_W-1:0]          i_rd_data,
    input  wire logic [AW-1:0]           i_cmp_idx,
    output logic [AW-1:0]                o_best_idx,
    output logic [BEST_W-1:0]            o_best_val,
    output logic signed [Q_W-1:0]        o_new_q
);

    localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN = 36'shF_8000_0000;

    logic signed [Q_W-1:0]   r_reward;
    logic signed [Q_W-1:0]   r_q;
    logic [BEST_W+FRAC_W-1:0] r_gprod;
    logic signed [33:0]      r_diff;
    logic signed [50:0]      r_sprod;
    logic signed [33:0]      w_diff;
    logic signed [35:0]      w_sum;
    logic                    w_better;

    // new row entry beats the running best
    assign w_better = $signed(i_rd_data) > $signed({1'b0, o_best_val});

    // target minus old entry, full width
    assign w_diff = 34'(r_reward) + $signed({3'b000, r_gprod[BEST_W+FRAC_W-1:FRAC_W]})
                  - 34'(r_q);

    // old entry plus floored step
    assign w_sum = 36'(r_q) + 36'(r_sprod >>> FRAC_W);

    // row scan, first index wins on a tie
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_reward   <= i_reward;
            o_best_val <= '0;
            o_best_idx <= '0;
        end else if (i_ctl.cmp && w_better) begin
            o_best_val <= i_rd_data[BEST_W-1:0];
            o_best_idx <= i_cmp_idx;
        end
    end

    // update pipeline, one register per step
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul1) begin
            r_q     <= $signed(i_rd_data);
            r_gprod <= {{BEST_W{1'b0}}, i_gamma} * {{FRAC_W{1'b0}}, o_best_val};
        end
        if (i_ctl.sub) begin
            r_diff <= w_diff;
        end
        if (i_ctl.mul2) begin
            r_sprod <= 51'($signed({1'b0, i_alpha})) * 51'(r_diff);
        end
        if (i_ctl.sat) begin
            priority if (w_sum > SAT_MAX) begin
                o_new_q <= SAT_MAX[Q_W-1:0];
            end else if (w_sum < SAT_MIN) begin
                o_new_q <= SAT_MIN[Q_W-1:0];
            end else begin
                o_new_q <= w_sum[Q_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/tabular_q_value_update_unit.sv @@
// tabular_q_value_update_unit: top level, sequencer, configuration and output register
// depends on qvu_pkg, qvu_qtable and qvu_arith
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries the state reached, the action
//   taken in the previous state and the reward. Output channel (o_out_valid /
//   i_out_stall) returns the updated q value, the best action and best value of
//   the new state's row. An item moves when valid is high and stall is low.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) writes alpha at
//   index 0 and gamma at index 1; other indexes are ignored.
//   Items are taken one at a time: o_in_stall stays high from acceptance until the
//   sequencer is idle again. The row is read one entry per cycle from the table
//   memory, then the old entry is read, two multiplies and a saturate run, and the
//   entry is written. Reset: the table is cleared by a pass of one entry per
//   cycle over all 2^(clog2 states + clog2 actions) entries (2048 by default),
//   with o_in_stall high. Stall: the result waits in the output register; the next
//   item is accepted and worked on, and finishes once that register is free.
`default_nettype none

module tabular_q_value_update_unit
    import qvu_pkg::*;
#(
    parameter int NUM_STATES  = DEF_NUM_STATES,
    parameter int NUM_ACTIONS = DEF_NUM_ACTIONS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input items
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [STATE_IN_W-1:0]   i_current_state,
    input  wire logic [ACTION_IN_W-1:0]  i_chosen_action,
    input  wire logic signed [Q_W-1:0]   i_reward_value,
    // result items
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [Q_W-1:0]        o_updated_value,
    output logic [ACTION_IN_W-1:0]       o_best_action,
    output logic [BEST_W-1:0]            o_best_value,
    // configuration writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [FRAC_W-1:0]       i_cfg_data
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int AW = $clog2(NUM_ACTIONS);
    localparam int TW = SW + AW;
    localparam logic [AW-1:0] LAST_ACT = AW'(NUM_ACTIONS - 1);
    localparam logic [SW-1:0] LAST_ST  = SW'(NUM_STATES - 1);

    t_state            r_state, n_state;
    logic [SW-1:0]     r_cur, r_prev;
    logic [AW-1:0]     r_act, r_idx, r_cmp_idx;
    logic              r_cmp_vld;
    logic [TW-1:0]     r_clr_addr;
    logic [FRAC_W-1:0] r_alpha, r_gamma;

    logic [SW-1:0]     w_state_map [1 << STATE_IN_W];
    logic [AW-1:0]     w_act_map   [1 << ACTION_IN_W];
    logic              w_accept, w_out_free, w_out_load;
    logic              w_we;
    logic [TW-1:0]     w_waddr, w_raddr;
    logic [Q_W-1:0]    w_wdata, w_rdata;
    t_arith_ctl        w_ctl;
    logic [AW-1:0]     w_best_idx;
    logic [BEST_W-1:0] w_best_val;
    logic signed [Q_W-1:0] w_new_q;

    // index reduction tables, worked out at elaboration
    for (genvar g = 0; g < (1 << STATE_IN_W); g++) begin : g_state_map
        assign w_state_map[g] = SW'(g % NUM_STATES);
    end
    for (genvar g = 0; g < (1 << ACTION_IN_W); g++) begin : g_act_map
        assign w_act_map[g] = AW'(g % NUM_ACTIONS);
    end

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !o_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == '1) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:  if (r_idx == LAST_ACT) n_state = ST_QREAD;
            ST_QREAD: n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_SUB;
            ST_SUB:   n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_SAT;
            ST_SAT:   n_state = ST_WRITE;
            ST_WRITE: n_state = w_out_free ? ST_IDLE : ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_ctl      = '0;
        w_ctl.accept = w_accept;
        w_ctl.cmp    = r_cmp_vld;
        w_ctl.mul1   = (r_state == ST_MUL1);
        w_ctl.sub    = (r_state == ST_SUB);
        w_ctl.mul2   = (r_state == ST_MUL2);
        w_ctl.sat    = (r_state == ST_SAT);
        w_out_load = ((r_state == ST_WRITE) || (r_state == ST_OUT)) && w_out_free;
        w_we       = (r_state == ST_CLEAR) || (r_state == ST_WRITE);
        w_waddr    = (r_state == ST_CLEAR) ? r_clr_addr : {r_prev, r_act};
        w_wdata    = (r_state == ST_CLEAR) ? '0 : w_new_q;
        w_raddr    = (r_state == ST_SCAN) ? {r_cur, r_idx} : {r_prev, r_act};
    end

    // sequencer and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_prev     <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + TW'(1);
            end
            if (w_accept) begin
                r_idx <= '0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + AW'(1);
            end
            if (r_state == ST_WRITE) begin
                r_prev <= r_cur;
            end
        end
    end

    // item capture and compare index
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (w_accept) begin
            r_cur <= w_state_map[i_current_state];
            r_act <= w_act_map[i_chosen_action];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_gamma <= GAMMA_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LEARNING_RATE:   r_alpha <= i_cfg_data;
                CFG_DISCOUNT_FACTOR: r_gamma <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_updated_value <= w_new_q;
            o_best_action   <= ACTION_IN_W'(w_best_idx);
            o_best_value    <= w_best_val;
        end
    end

    qvu_qtable #(
        .ADDR_W (TW)
    ) u_qtable (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    qvu_arith #(
        .AW (AW)
    ) u_arith (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_alpha    (r_alpha),
        .i_gamma    (r_gamma),
        .i_reward   (i_reward_value),
        .i_rd_data  (w_rdata),
        .i_cmp_idx  (r_cmp_idx),
        .o_best_idx (w_best_idx),
        .o_best_val (w_best_val),
        .o_new_q    (w_new_q)
    );

    // scan never runs past the last action
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= LAST_ACT))
        else $error("row scan index beyond last action");

    // an accepted item always starts a row scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN))
        else $error("accepted item did not start a scan");

    // stored previous state stays within the table
    a_prev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev <= LAST_ST)
        else $error("previous state out of range");

    // a fresh result only comes from the write back path
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_WRITE || $past(r_state) == ST_OUT))
        else $error("result raised outside write back");

    // table writes only during clearing or write back
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_CLEAR || r_state == ST_WRITE))
        else $error("unexpected table write");

endmodule

`default_nettype wire

@@ verif/tabular_q_value_update_unit_tb.sv @@
// tabular_q_value_update_unit_tb: self-checking testbench for the q value update unit
// holds its own mirror of the q table and registers and checks every result item
// depends on qvu_pkg and tabular_q_value_update_unit
module tabular_q_value_update_unit_tb
    import qvu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_STATES  = DEF_NUM_STATES;
    localparam int N_ACTIONS = DEF_NUM_ACTIONS;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = N_ACTIONS + 10;
    localparam int REPORT_CAP = 100;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam logic signed [Q_W-1:0] ONE = 32'sd65536;

    // register indexes that the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [STATE_IN_W-1:0]  state;
        logic [ACTION_IN_W-1:0] action;
        logic signed [Q_W-1:0]  reward;
    } t_q_item;

    typedef struct packed {
        logic signed [Q_W-1:0]  value;
        logic [ACTION_IN_W-1:0] action;
        logic [BEST_W-1:0]      best;
    } t_q_result;

    // dut ports
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [STATE_IN_W-1:0]       i_current_state = '0;
    logic [ACTION_IN_W-1:0]      i_chosen_action = '0;
    logic signed [Q_W-1:0]       i_reward_value = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [Q_W-1:0]       o_updated_value;
    logic [ACTION_IN_W-1:0]      o_best_action;
    logic [BEST_W-1:0]           o_best_value;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [FRAC_W-1:0]           i_cfg_data = '0;

    // mirror of the block state
    logic signed [Q_W-1:0]       q_mirror [N_STATES*N_ACTIONS];
    int unsigned                 prev_row = 0;
    logic [FRAC_W-1:0]           alpha_q16 = ALPHA_RESET;
    logic [FRAC_W-1:0]           gamma_q16 = GAMMA_RESET;

    t_q_item                     item_queue [$];
    t_q_result                   result_queue [$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int saturation_hits = 0;
    int cycle_count = 0;

    tabular_q_value_update_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_current_state (i_current_state),
        .i_chosen_action (i_chosen_action),
        .i_reward_value  (i_reward_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_updated_value (o_updated_value),
        .o_best_action   (o_best_action),
        .o_best_value    (o_best_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // row scan on the old row, then update of the previous state's entry
    function automatic t_q_result advance_q_table(input logic [STATE_IN_W-1:0] state_in,
                                                  input logic [ACTION_IN_W-1:0] action_in,
                                                  input logic signed [Q_W-1:0] reward);
        t_q_result   r;
        int unsigned row;
        int unsigned slot;
        int unsigned best_idx;
        longint      best;
        longint      q_old;
        longint      target;
        longint      diff;
        longint      nq;
        row = int'(state_in) % N_STATES;
        best = 0;
        best_idx = 0;
        for (int a = 0; a < N_ACTIONS; a++) begin
            if (longint'(q_mirror[row*N_ACTIONS + a]) > best) begin
                best = q_mirror[row*N_ACTIONS + a];
                best_idx = a;
            end
        end
        slot = prev_row*N_ACTIONS + (int'(action_in) % N_ACTIONS);
        q_old = q_mirror[slot];
        target = longint'(reward) + ((longint'(gamma_q16) * best) >>> FRAC_W);
        diff = target - q_old;
        nq = q_old + ((longint'(alpha_q16) * diff) >>> FRAC_W);
        if (nq > Q_MAX) begin
            nq = Q_MAX;
            saturation_hits++;
        end else if (nq < Q_MIN) begin
            nq = Q_MIN;
            saturation_hits++;
        end
        q_mirror[slot] = nq[Q_W-1:0];
        prev_row = row;
        r.value = nq[Q_W-1:0];
        r.action = best_idx[ACTION_IN_W-1:0];
        r.best = best[BEST_W-1:0];
        return r;
    endfunction

    // random item: mostly a few hot states so rows fill up and ties appear
    function automatic t_q_item random_item();
        t_q_item it;
        int      pick;
        int      level;
        pick = $urandom_range(99);
        if (pick < 65)
            it.state = STATE_IN_W'($urandom_range(7));
        else if (pick < 75)
            it.state = $urandom_range(1) ? 8'hFF : 8'h00;
        else
            it.state = STATE_IN_W'($urandom_range(255));
        it.action = ACTION_IN_W'($urandom_range(N_ACTIONS - 1));
        pick = $urandom_range(99);
        if (pick < 40) begin
            level = int'($urandom_range(4)) - 2;
            it.reward = level * 65536;
        end else if (pick < 70) begin
            it.reward = int'($urandom_range(1 << 21)) - (1 << 20);
        end else if (pick < 85) begin
            it.reward = $urandom;
        end else begin
            case ($urandom_range(3))
                0: it.reward = 32'sh7FFFFFFF;
                1: it.reward = 32'sh80000000;
                2: it.reward = 32'sh00000000;
                default: it.reward = 32'shFFFFFFFF;
            endcase
        end
        return it;
    endfunction

    // input driver: holds the payload while stalled, gaps at random
    always @(posedge i_clk) begin
        t_q_item nxt;
        logic    take;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take) begin
                result_queue.push_back(advance_q_table(i_current_state, i_chosen_action,
                                                       i_reward_value));
                items_sent++;
            end
            if (!i_in_valid || take) begin
                if (item_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = item_queue.pop_front();
                    i_current_state <= nxt.state;
                    i_chosen_action <= nxt.action;
                    i_reward_value <= nxt.reward;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        t_q_result want;
        logic      bad;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (result_queue.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result item with none expected: value %0d action %0d best %0d",
                             $time, o_updated_value, o_best_action, o_best_value);
                end else begin
                    want = result_queue.pop_front();
                    results_checked++;
                    bad = 1'b0;
                    // printing stops after a cap so a broken block cannot flood the log
                    if (o_updated_value !== want.value) begin
                        bad = 1'b1;
                        if (mismatch_count < REPORT_CAP)
                            $display("%0t ns: updated_value expected %0d actual %0d",
                                     $time, want.value, o_updated_value);
                    end
                    if (o_best_action !== want.action) begin
                        bad = 1'b1;
                        if (mismatch_count < REPORT_CAP)
                            $display("%0t ns: best_action expected %0d actual %0d",
                                     $time, want.action, o_best_action);
                    end
                    if (o_best_value !== want.best) begin
                        bad = 1'b1;
                        if (mismatch_count < REPORT_CAP)
                            $display("%0t ns: best_value expected %0d actual %0d",
                                     $time, want.best, o_best_value);
                    end
                    if (bad)
                        mismatch_count++;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("tabular_q_value_update_unit regression: fail");
            $finish;
        end
    end

    task automatic queue_item(input logic [STATE_IN_W-1:0] state,
                              input logic [ACTION_IN_W-1:0] action,
                              input logic signed [Q_W-1:0] reward);
        t_q_item it;
        it.state = state;
        it.action = action;
        it.reward = reward;
        item_queue.push_back(it);
    endtask

    // wait until every item is sent and every result has come back
    task automatic wait_drained();
        @(posedge i_clk);
        while (item_queue.size() != 0 || i_in_valid || result_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [FRAC_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_LEARNING_RATE)
            alpha_q16 = value;
        else if (idx == CFG_DISCOUNT_FACTOR)
            gamma_q16 = value;
    endtask

    task automatic play_random(input int count, input int send_pct, input int recv_pct);
        send_gap_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            item_queue.push_back(random_item());
        wait_drained();
    endtask

    // main sequence
    initial begin
        foreach (q_mirror[k])
            q_mirror[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items under the reset values of alpha and gamma
        send_gap_pct = 27;
        recv_stall_pct = 88;
        queue_item(8'd0, 3'd0, 32'sd0);
        queue_item(8'd0, 3'd7, 32'sh7FFFFFFF);
        queue_item(8'd0, 3'd0, 32'sh80000000);
        queue_item(8'd255, 3'd7, 10 * ONE);
        // previous state equal to current state: scan must see the old row
        queue_item(8'd255, 3'd3, 4 * ONE);
        queue_item(8'd255, 3'd5, 4 * ONE);
        queue_item(8'd255, 3'd3, 4 * ONE);
        // two rewarded entries in row 10, then a scan of that row
        queue_item(8'd10, 3'd1, 32'sd0);
        queue_item(8'd20, 3'd2, 4 * ONE);
        queue_item(8'd10, 3'd0, 32'sd0);
        queue_item(8'd20, 3'd6, 4 * ONE);
        queue_item(8'd10, 3'd1, 32'sd0);
        // negative entries in row 30 never beat the starting best of 0 at action 0
        queue_item(8'd30, 3'd0, 32'sd0);
        queue_item(8'd40, 3'd4, -8 * ONE);
        queue_item(8'd30, 3'd0, 32'sd0);
        queue_item(8'd30, 3'd2, -1);
        queue_item(8'd30, 3'd7, 32'sh80000000);
        queue_item(8'd30, 3'd0, 32'sd0);
        // bit pattern sweep on state and reward
        queue_item(8'hAA, 3'd5, 32'sh55555555);
        queue_item(8'h55, 3'd2, 32'shAAAAAAAA);
        queue_item(8'hAA, 3'd1, 32'sh0000FFFF);
        queue_item(8'h55, 3'd6, 32'shFFFF0000);
        wait_drained();

        play_random(200, 27, 88);

        program_reg(CFG_LEARNING_RATE, 16'hFFFF);
        program_reg(CFG_DISCOUNT_FACTOR, 16'hFFFF);
        play_random(250, 27, 88);

        program_reg(CFG_LEARNING_RATE, 16'h0000);
        program_reg(CFG_DISCOUNT_FACTOR, 16'h0000);
        // writes to indexes with no register must change nothing
        program_reg(CFG_SPARE_2, 16'hFFFF);
        program_reg(CFG_SPARE_3, 16'h1234);
        play_random(150, 88, 27);

        program_reg(CFG_LEARNING_RATE, 16'h0001);
        program_reg(CFG_DISCOUNT_FACTOR, 16'hFFFF);
        play_random(150, 88, 27);

        program_reg(CFG_LEARNING_RATE, 16'h8000);
        program_reg(CFG_DISCOUNT_FACTOR, 16'h0000);
        play_random(200, 88, 27);

        program_reg(CFG_LEARNING_RATE, 16'($urandom));
        program_reg(CFG_DISCOUNT_FACTOR, 16'($urandom));
        play_random(500, 0, 0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d items and %0d checked results over %0d register writes",
                 items_sent, results_checked, reg_writes);
        $display("alpha and gamma swept through 0 and full scale, %0d updates saturated",
                 saturation_hits);
        if (mismatch_count == 0 && result_queue.size() == 0) begin
            $display("tabular_q_value_update_unit regression: pass");
        end else begin
            $display("%0d bad result items, %0d still expected",
                     mismatch_count, result_queue.size());
            $display("tabular_q_value_update_unit regression: fail");
        end
        $finish;
    end

endmodule
